>>> src/thermal_profile_sequencer_top_defines.svh
// Assertion macros for the thermal profile sequencer.
// Each macro checks its property on the rising edge of clock.
`ifndef THERMAL_PROFILE_SEQUENCER_TOP_DEFINES_SVH
`define THERMAL_PROFILE_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("thermal profile sequencer assertion failed");
`define TPS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("thermal profile sequencer assertion failed");
`else
`define TPS_ASSERT(label, prop)
`define TPS_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> src/thps_pkg.sv
package thps_pkg;

   localparam int NUM_STEPS_DEFAULT = 11;
   localparam int STEP_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int HYST_W = 17;
   localparam int TARGET_MC_W = 19;

   localparam logic [HYST_W-1:0] HYSTERESIS_RESET = 17'd1000;
   localparam logic CSR_IDX_HYSTERESIS = 1'b0;

   localparam logic [31:0] MS_PER_S = 32'd1000;
   localparam logic [TARGET_MC_W-1:0] MC_PER_DEG = 19'd1000;

   typedef struct packed {
      logic [19:0] temperature_mc;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic             heater_on;
      logic [STEP_W-1:0] step_now;
      logic             profile_done;
   } rsp_type;

   typedef struct packed {
      logic [19:0] hold_s;
      logic [8:0]  target_c;
      logic        exit_on_temp;
      logic        heat_enable;
   } entry_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_idx;
   } status_type;

   // Built-in reflow profile; steps past the eleventh are all zero.
   function automatic entry_type profile_entry(input logic [STEP_W-1:0] idx);
      entry_type e;
      unique case (idx)
         4'd0:    e = '{20'd5,      9'd0,   1'b0, 1'b0};
         4'd1:    e = '{20'd5,      9'd100, 1'b0, 1'b1};
         4'd2:    e = '{20'd0,      9'd100, 1'b1, 1'b1};
         4'd3:    e = '{20'd20,     9'd100, 1'b0, 1'b1};
         4'd4:    e = '{20'd0,      9'd150, 1'b1, 1'b1};
         4'd5:    e = '{20'd20,     9'd150, 1'b0, 1'b1};
         4'd6:    e = '{20'd0,      9'd200, 1'b1, 1'b1};
         4'd7:    e = '{20'd20,     9'd200, 1'b0, 1'b1};
         4'd8:    e = '{20'd0,      9'd240, 1'b1, 1'b1};
         4'd9:    e = '{20'd10,     9'd240, 1'b0, 1'b1};
         4'd10:   e = '{20'd999999, 9'd0,   1'b0, 1'b0};
         default: e = '{20'd0,      9'd0,   1'b0, 1'b0};
      endcase
      return e;
   endfunction

endpackage

>>> src/thps_csr.sv
module thps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [thps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [thps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [thps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [thps_pkg::HYST_W-1:0]         hysteresis
);

   logic [thps_pkg::HYST_W-1:0] hyst_ff;
   logic [thps_pkg::HYST_W-1:0] hyst_in;
   logic                        hit;

   // Registers sit on 32-bit words; bit 2 picks the word.
   assign hit = (csr_paddr[2] == thps_pkg::CSR_IDX_HYSTERESIS);

   always_comb begin
      hyst_in = hyst_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         hyst_in = csr_pwdata[thps_pkg::HYST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff <= thps_pkg::HYSTERESIS_RESET;
      end else begin
         hyst_ff <= hyst_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {{(thps_pkg::CSR_DATA_W - thps_pkg::HYST_W){1'b0}}, hyst_ff}
                           : '0;
   assign hysteresis = hyst_ff;

endmodule

>>> src/thps_step.sv
module thps_step #(
   parameter int NUM_STEPS = thps_pkg::NUM_STEPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  thps_pkg::req_type           req,
   input  logic [thps_pkg::HYST_W-1:0] hysteresis,
   output thps_pkg::rsp_type           rsp,
   output thps_pkg::status_type        status
);

   localparam logic [thps_pkg::STEP_W-1:0] LAST_STEP = thps_pkg::STEP_W'(NUM_STEPS - 1);

   logic [thps_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [31:0]                      start_ff, start_in;
   thps_pkg::entry_type              cur_e, nxt_e, act_e;
   logic [31:0]                      dur_ms, elapsed;
   logic [thps_pkg::TARGET_MC_W-1:0] cur_target_mc, act_target_mc, hyst_ext, heat_limit;
   logic                             advance, do_adv, heat;

   always_comb begin
      cur_e         = thps_pkg::profile_entry(step_ff);
      nxt_e         = thps_pkg::profile_entry(step_ff + 4'd1);
      dur_ms        = 32'(cur_e.hold_s) * thps_pkg::MS_PER_S;
      cur_target_mc = thps_pkg::TARGET_MC_W'(cur_e.target_c) * thps_pkg::MC_PER_DEG;
      elapsed       = req.now_ms - start_ff;

      if (cur_e.exit_on_temp) begin
         advance = req.temperature_mc >= {1'b0, cur_target_mc};
      end else begin
         advance = elapsed >= dur_ms;
      end
      // The final step holds its index and start time.
      do_adv = advance && (step_ff < LAST_STEP);

      act_e         = do_adv ? nxt_e : cur_e;
      act_target_mc = thps_pkg::TARGET_MC_W'(act_e.target_c) * thps_pkg::MC_PER_DEG;
      hyst_ext      = thps_pkg::TARGET_MC_W'(hysteresis);
      heat_limit    = act_target_mc - hyst_ext;
      // A target at or below the margin keeps the heater off.
      heat = act_e.heat_enable && (act_target_mc > hyst_ext) &&
             (req.temperature_mc < {1'b0, heat_limit});

      step_in  = step_ff;
      start_in = start_ff;
      if (fire && do_adv) begin
         step_in  = step_ff + 4'd1;
         start_in = req.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         start_ff <= '0;
      end else begin
         step_ff  <= step_in;
         start_ff <= start_in;
      end
   end

   always_comb begin
      rsp.heater_on    = heat;
      rsp.step_now     = do_adv ? (step_ff + 4'd1) : step_ff;
      rsp.profile_done = (rsp.step_now == LAST_STEP);
      status.step_idx  = step_ff;
   end

endmodule

>>> src/thermal_profile_sequencer_top.sv
// Thermal profile sequencer: walks a built-in reflow profile one sample at a time.
// The req channel carries one sample per transfer: the oven temperature in
// millidegrees and the free-running millisecond time. The rsp channel returns
// exactly one result per sample: heater drive, the active step and a done flag.
// Both channels use valid/ready; a transfer happens when both are high.
// The csr port is APB-style with pready tied high; word 0 holds the heater
// hysteresis in millidegrees. Write it only while no sample is in flight.
// A req transfer loads the input register; the step stage then loads the
// result register, which raises rsp_valid, once that register is free.
// Throughput: one sample per cycle while the receiver takes results; the
// step state is read and updated by a single compare-and-select stage
// between the input and result registers.
// When the receiver stalls, the result register holds its value and the
// input register keeps one more sample, after which req_ready drops.
// Synchronous reset returns the profile to step 0 with start time 0, sets the
// hysteresis to 1000 millidegrees and empties both pipeline registers.
`include "thermal_profile_sequencer_top_defines.svh"

module thermal_profile_sequencer_top #(
   parameter int NUM_STEPS = thps_pkg::NUM_STEPS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  thps_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output thps_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [thps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [thps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [thps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam logic [thps_pkg::STEP_W-1:0] LAST_STEP = thps_pkg::STEP_W'(NUM_STEPS - 1);

   logic                        s1_valid_ff, s1_valid_in;
   thps_pkg::req_type           s1_data_ff, s1_data_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   thps_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                        out_free, s1_fire, req_fire;
   logic [thps_pkg::HYST_W-1:0] hysteresis;
   thps_pkg::rsp_type           step_rsp;
   thps_pkg::status_type        status;

   thps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hysteresis  (hysteresis)
   );

   // The step stage runs on the sample held in the input register and
   // commits its state change in the same cycle the result is captured.
   thps_step #(
      .NUM_STEPS (NUM_STEPS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .fire       (s1_fire),
      .req        (s1_data_ff),
      .hysteresis (hysteresis),
      .rsp        (step_rsp),
      .status     (status)
   );

   // The result register is free when empty or when its transfer completes
   // in this cycle, so the stage keeps moving while the receiver takes data.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The step index only moves when a sample passes through the step stage,
   // and then by at most one.
   `TPS_ASSERT(a_step_holds_idle, !s1_fire |=> $stable(status.step_idx))
   `TPS_ASSERT(a_step_moves_by_one, s1_fire |=> status.step_idx - $past(status.step_idx) <= 4'd1)
   // A delivered result never points past the final step, and the done flag
   // agrees with the index it carries.
   `TPS_ASSERT(a_rsp_step_bound, rsp_valid |-> rsp_data.step_now <= LAST_STEP)
   `TPS_ASSERT(a_done_flag, rsp_valid |-> rsp_data.profile_done == (rsp_data.step_now == LAST_STEP))
   // The input register never drops a sample while a result waits.
   `TPS_ASSERT_ALWAYS(a_no_overrun, (s1_valid_ff && !out_free) |-> !req_ready)

endmodule
